// ----- rtl/anbd_pkg.sv -----
package anbd_pkg;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_JUNK = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  localparam int unsigned IDX_BITS        = 32;
  localparam logic [7:0]  START_CODE_BYTE = 8'h01;
  localparam logic [7:0]  ZERO_BYTE       = 8'h00;
  localparam logic [2:0]  PREFIX_NONE     = 3'd0;
  localparam logic [2:0]  PREFIX_SHORT    = 3'd3;
  localparam logic [2:0]  PREFIX_LONG     = 3'd4;
  localparam logic [1:0]  ZRUN_MAX        = 2'd3;
  localparam logic [1:0]  ZRUN_SC_MIN     = 2'd2;

endpackage

// ----- rtl/anbd_in_stage.sv -----
module anbd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  input  logic       adv,
  output logic       stage_valid,
  output logic [7:0] stage_data,
  output logic       stage_eos
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       eos_r;

  assign in_ready    = !valid_r || adv;
  assign stage_valid = valid_r;
  assign stage_data  = data_r;
  assign stage_eos   = eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      eos_r  <= in_end_of_stream;
    end
  end

endmodule

// ----- rtl/anbd_core.sv -----
module anbd_core #(
  parameter int unsigned LEN_BITS    = 24,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [7:0]                    data,
  input  logic                          eos,
  output logic                          res_valid,
  output logic [1:0]                    res_status,
  output logic [anbd_pkg::IDX_BITS-1:0] res_index,
  output logic [OFFSET_BITS-1:0]        res_offset,
  output logic [2:0]                    res_prefix,
  output logic [LEN_BITS-1:0]           res_len,
  output logic [7:0]                    res_hdr
);

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  logic [1:0]                    zero_run_r, zero_run_nxt;
  logic [OFFSET_BITS-1:0]        byte_pos_r, byte_pos_nxt;
  logic [OFFSET_BITS-1:0]        unit_start_r, unit_start_nxt;
  logic [2:0]                    unit_prefix_r, unit_prefix_nxt;
  logic                          synced_r, synced_nxt;
  logic                          header_seen_r, header_seen_nxt;
  logic [7:0]                    header_byte_r, header_byte_nxt;
  logic [LEN_BITS-1:0]           payload_count_r, payload_count_nxt;
  logic [LEN_BITS-1:0]           junk_count_r, junk_count_nxt;
  logic [anbd_pkg::IDX_BITS-1:0] unit_counter_r, unit_counter_nxt;

  logic                   sc;
  logic                   four;
  logic [LEN_BITS-1:0]    zeros_len;
  logic [OFFSET_BITS-1:0] zeros_off;
  logic                   pay_sat, junk_sat;
  logic [LEN_BITS-1:0]    pay_trim, junk_trim, junk_len;
  logic [7:0]             hdr_raw;

  always_comb begin
    sc        = (data == anbd_pkg::START_CODE_BYTE) && (zero_run_r >= anbd_pkg::ZRUN_SC_MIN);
    four      = (zero_run_r == anbd_pkg::ZRUN_MAX);
    zeros_len = {{(LEN_BITS-2){1'b0}}, (four ? 2'd3 : 2'd2)};
    zeros_off = {{(OFFSET_BITS-2){1'b0}}, (four ? 2'd3 : 2'd2)};
    pay_sat   = (payload_count_r == LEN_MAX);
    junk_sat  = (junk_count_r == LEN_MAX);
    pay_trim  = (payload_count_r >= zeros_len) ? payload_count_r - zeros_len : '0;
    junk_trim = (junk_count_r >= zeros_len) ? junk_count_r - zeros_len : '0;
    junk_len  = junk_sat ? LEN_MAX : junk_trim;

    zero_run_nxt      = zero_run_r;
    byte_pos_nxt      = byte_pos_r + 1'b1;
    unit_start_nxt    = unit_start_r;
    unit_prefix_nxt   = unit_prefix_r;
    synced_nxt        = synced_r;
    header_seen_nxt   = header_seen_r;
    header_byte_nxt   = header_byte_r;
    payload_count_nxt = payload_count_r;
    junk_count_nxt    = junk_count_r;
    unit_counter_nxt  = unit_counter_r;

    res_valid  = 1'b0;
    res_status = anbd_pkg::STATUS_DONE;
    res_index  = unit_counter_r;
    res_offset = '0;
    res_prefix = anbd_pkg::PREFIX_NONE;
    res_len    = '0;
    hdr_raw    = '0;

    if (sc) begin
      if (synced_r) begin
        // previous unit closes here, its start-code zeros trimmed
        res_valid        = 1'b1;
        res_status       = pay_sat ? anbd_pkg::STATUS_SAT : anbd_pkg::STATUS_DONE;
        res_offset       = unit_start_r;
        res_prefix       = unit_prefix_r;
        res_len          = pay_sat ? LEN_MAX : pay_trim;
        hdr_raw          = header_byte_r;
        unit_counter_nxt = unit_counter_r + 1'b1;
      end else if (junk_len != '0) begin
        res_valid  = 1'b1;
        res_status = anbd_pkg::STATUS_JUNK;
        res_len    = junk_len;
      end
      synced_nxt        = 1'b1;
      unit_start_nxt    = byte_pos_r - zeros_off;
      unit_prefix_nxt   = four ? anbd_pkg::PREFIX_LONG : anbd_pkg::PREFIX_SHORT;
      header_seen_nxt   = 1'b0;
      header_byte_nxt   = '0;
      payload_count_nxt = '0;
      zero_run_nxt      = '0;
    end else begin
      if (synced_r) begin
        if (!header_seen_r) begin
          header_byte_nxt = data;
          header_seen_nxt = 1'b1;
        end
        if (!pay_sat) payload_count_nxt = payload_count_r + 1'b1;
      end else if (!junk_sat) begin
        junk_count_nxt = junk_count_r + 1'b1;
      end
      if (data == anbd_pkg::ZERO_BYTE) begin
        if (zero_run_r != anbd_pkg::ZRUN_MAX) zero_run_nxt = zero_run_r + 1'b1;
      end else begin
        zero_run_nxt = '0;
      end
    end

    if (eos) begin
      // stream end flushes the open unit with trailing zeros kept
      if (!sc) begin
        if (synced_r) begin
          res_valid  = 1'b1;
          res_status = (payload_count_nxt == LEN_MAX) ? anbd_pkg::STATUS_SAT
                                                      : anbd_pkg::STATUS_DONE;
          res_offset = unit_start_r;
          res_prefix = unit_prefix_r;
          res_len    = payload_count_nxt;
          hdr_raw    = header_byte_nxt;
        end else if (junk_count_nxt != '0) begin
          res_valid  = 1'b1;
          res_status = anbd_pkg::STATUS_JUNK;
          res_len    = junk_count_nxt;
        end
      end
      zero_run_nxt      = '0;
      byte_pos_nxt      = '0;
      unit_start_nxt    = '0;
      unit_prefix_nxt   = '0;
      synced_nxt        = 1'b0;
      header_seen_nxt   = 1'b0;
      header_byte_nxt   = '0;
      payload_count_nxt = '0;
      junk_count_nxt    = '0;
      unit_counter_nxt  = '0;
    end

    res_hdr = (res_len == '0) ? 8'h00 : hdr_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r      <= '0;
      byte_pos_r      <= '0;
      unit_start_r    <= '0;
      unit_prefix_r   <= '0;
      synced_r        <= 1'b0;
      header_seen_r   <= 1'b0;
      header_byte_r   <= '0;
      payload_count_r <= '0;
      junk_count_r    <= '0;
      unit_counter_r  <= '0;
    end else if (en) begin
      zero_run_r      <= zero_run_nxt;
      byte_pos_r      <= byte_pos_nxt;
      unit_start_r    <= unit_start_nxt;
      unit_prefix_r   <= unit_prefix_nxt;
      synced_r        <= synced_nxt;
      header_seen_r   <= header_seen_nxt;
      header_byte_r   <= header_byte_nxt;
      payload_count_r <= payload_count_nxt;
      junk_count_r    <= junk_count_nxt;
      unit_counter_r  <= unit_counter_nxt;
    end
  end

endmodule

// ----- rtl/annexb_nal_unit_delimiter.sv -----
// Annex B start-code delimiter: takes one stream byte per transfer and returns one record
// per finished NAL unit (offset, prefix length, payload length, header fields), plus one
// record for any bytes skipped before the first start code. It accepts one byte every
// cycle while not stalled; a byte is registered in the input stage, and its record,
// if any, is registered in the output register when that byte moves on. The core
// updates its state once per byte, and intake stalls only when a record waits in the
// output register and out_ready is low.
module annexb_nal_unit_delimiter #(
  parameter int unsigned LEN_BITS    = 24,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_stream,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_result_status,
  output logic [anbd_pkg::IDX_BITS-1:0] out_unit_index,
  output logic [OFFSET_BITS-1:0]        out_start_offset,
  output logic [2:0]                    out_prefix_length,
  output logic [LEN_BITS-1:0]           out_payload_length,
  output logic                          out_forbidden_bit,
  output logic [1:0]                    out_ref_idc,
  output logic [4:0]                    out_unit_type
);

  logic                          stage_valid;
  logic [7:0]                    stage_data;
  logic                          stage_eos;
  logic                          adv;
  logic                          load;
  logic                          res_valid;
  logic [1:0]                    res_status;
  logic [anbd_pkg::IDX_BITS-1:0] res_index;
  logic [OFFSET_BITS-1:0]        res_offset;
  logic [2:0]                    res_prefix;
  logic [LEN_BITS-1:0]           res_len;
  logic [7:0]                    res_hdr;

  logic                          out_valid_r;
  logic [1:0]                    status_r;
  logic [anbd_pkg::IDX_BITS-1:0] index_r;
  logic [OFFSET_BITS-1:0]        offset_r;
  logic [2:0]                    prefix_r;
  logic [LEN_BITS-1:0]           len_r;
  logic [7:0]                    hdr_r;

  // the staged byte moves on whenever the result register is free or draining
  assign adv  = stage_valid && (!out_valid_r || out_ready);
  assign load = adv && res_valid;

  anbd_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .adv              (adv),
    .stage_valid      (stage_valid),
    .stage_data       (stage_data),
    .stage_eos        (stage_eos)
  );

  anbd_core #(
    .LEN_BITS    (LEN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .data       (stage_data),
    .eos        (stage_eos),
    .res_valid  (res_valid),
    .res_status (res_status),
    .res_index  (res_index),
    .res_offset (res_offset),
    .res_prefix (res_prefix),
    .res_len    (res_len),
    .res_hdr    (res_hdr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res_status;
      index_r  <= res_index;
      offset_r <= res_offset;
      prefix_r <= res_prefix;
      len_r    <= res_len;
      hdr_r    <= res_hdr;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_status  = status_r;
  assign out_unit_index     = index_r;
  assign out_start_offset   = offset_r;
  assign out_prefix_length  = prefix_r;
  assign out_payload_length = len_r;
  assign out_forbidden_bit  = hdr_r[7];
  assign out_ref_idc        = hdr_r[6:5];
  assign out_unit_type      = hdr_r[4:0];

endmodule

// ----- rtl/anbd_checker.sv -----
module anbd_checker #(
  parameter int unsigned LEN_BITS    = 24,
  parameter int unsigned OFFSET_BITS = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             out_result_status,
  input logic [OFFSET_BITS-1:0] out_start_offset,
  input logic [2:0]             out_prefix_length,
  input logic [LEN_BITS-1:0]    out_payload_length,
  input logic                   out_forbidden_bit,
  input logic [1:0]             out_ref_idc,
  input logic [4:0]             out_unit_type
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_length))
    else $error("result dropped or changed while stalled");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_status == anbd_pkg::STATUS_JUNK)
                   ? (out_prefix_length == anbd_pkg::PREFIX_NONE
                      && out_start_offset == '0)
                   : (out_prefix_length == anbd_pkg::PREFIX_SHORT
                      || out_prefix_length == anbd_pkg::PREFIX_LONG)))
    else $error("prefix length does not match record kind");

  a_junk_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_status == anbd_pkg::STATUS_JUNK |-> out_payload_length != '0)
    else $error("empty junk record");

  a_empty_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_length == '0
      |-> !out_forbidden_bit && out_ref_idc == 2'd0 && out_unit_type == 5'd0)
    else $error("empty unit carries header fields");

endmodule

bind annexb_nal_unit_delimiter anbd_checker #(
  .LEN_BITS    (LEN_BITS),
  .OFFSET_BITS (OFFSET_BITS)
) u_anbd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_status  (out_result_status),
  .out_start_offset   (out_start_offset),
  .out_prefix_length  (out_prefix_length),
  .out_payload_length (out_payload_length),
  .out_forbidden_bit  (out_forbidden_bit),
  .out_ref_idc        (out_ref_idc),
  .out_unit_type      (out_unit_type)
);

// ----- test/nal_record_checker.sv -----
module nal_record_checker #(
  parameter int unsigned LEN_BITS    = 24,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_stream,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [1:0]                    out_result_status,
  input  logic [anbd_pkg::IDX_BITS-1:0] out_unit_index,
  input  logic [OFFSET_BITS-1:0]        out_start_offset,
  input  logic [2:0]                    out_prefix_length,
  input  logic [LEN_BITS-1:0]           out_payload_length,
  input  logic                          out_forbidden_bit,
  input  logic [1:0]                    out_ref_idc,
  input  logic [4:0]                    out_unit_type,
  output int unsigned                   fail_count,
  output int unsigned                   pending_count,
  output int unsigned                   records_checked,
  output int unsigned                   junk_records,
  output int unsigned                   bytes_seen
);

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  typedef struct packed {
    anbd_pkg::status_t                status;
    logic [anbd_pkg::IDX_BITS-1:0]    index;
    logic [OFFSET_BITS-1:0]           offset;
    logic [2:0]                       prefix;
    logic [LEN_BITS-1:0]              length;
    logic                             forbidden;
    logic [1:0]                       nri;
    logic [4:0]                       nal_type;
  } nal_record_t;

  nal_record_t expected_records[$];

  // delimiter state as the block should hold it
  logic [1:0]                    zeros_seen;
  logic [OFFSET_BITS-1:0]        stream_pos;
  logic [OFFSET_BITS-1:0]        open_start;
  logic [2:0]                    open_prefix;
  logic                          unit_active;
  logic                          hdr_captured;
  logic [7:0]                    hdr_byte;
  logic [LEN_BITS-1:0]           unit_bytes;
  logic [anbd_pkg::IDX_BITS-1:0] unit_num;
  logic                          in_sync;
  logic [LEN_BITS-1:0]           junk_bytes;

  function automatic nal_record_t make_record(input anbd_pkg::status_t st,
                                              input logic [anbd_pkg::IDX_BITS-1:0] idx,
                                              input logic [OFFSET_BITS-1:0] off,
                                              input logic [2:0] pre,
                                              input logic [LEN_BITS-1:0] len,
                                              input logic [7:0] hdr);
    nal_record_t r;
    logic [7:0]  h;
    // an empty unit never captured a header
    h = (len == '0) ? anbd_pkg::ZERO_BYTE : hdr;
    r.status    = st;
    r.index     = idx;
    r.offset    = off;
    r.prefix    = pre;
    r.length    = len;
    r.forbidden = h[7];
    r.nri       = h[6:5];
    r.nal_type  = h[4:0];
    return r;
  endfunction

  // drop the start-code zeros from a count unless it is pinned at the ceiling
  function automatic logic [LEN_BITS-1:0] trim_zeros(input logic [LEN_BITS-1:0] count,
                                                     input logic [2:0] zeros,
                                                     output logic sat);
    sat = (count == LEN_MAX);
    if (sat) return LEN_MAX;
    return (count >= LEN_BITS'(zeros)) ? count - LEN_BITS'(zeros) : '0;
  endfunction

  task automatic clear_state();
    zeros_seen   = '0;
    stream_pos   = '0;
    open_start   = '0;
    open_prefix  = anbd_pkg::PREFIX_NONE;
    unit_active  = 1'b0;
    hdr_captured = 1'b0;
    hdr_byte     = anbd_pkg::ZERO_BYTE;
    unit_bytes   = '0;
    unit_num     = '0;
    in_sync      = 1'b0;
    junk_bytes   = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eos);
    logic                   sc;
    logic [2:0]             pre;
    logic [2:0]             zeros;
    logic                   sat;
    logic [LEN_BITS-1:0]    len;
    logic [OFFSET_BITS-1:0] pos;
    pos = stream_pos;
    sc  = (b == anbd_pkg::START_CODE_BYTE) && (zeros_seen >= anbd_pkg::ZRUN_SC_MIN);
    if (sc) begin
      pre   = (zeros_seen >= anbd_pkg::ZRUN_MAX) ? anbd_pkg::PREFIX_LONG
                                                 : anbd_pkg::PREFIX_SHORT;
      zeros = pre - 3'd1;
      if (in_sync && unit_active) begin
        len = trim_zeros(unit_bytes, zeros, sat);
        expected_records.push_back(make_record(
            sat ? anbd_pkg::STATUS_SAT : anbd_pkg::STATUS_DONE, unit_num, open_start,
            open_prefix, len, hdr_byte));
        unit_num++;
      end else if (!in_sync) begin
        len = trim_zeros(junk_bytes, zeros, sat);
        if (len != '0)
          expected_records.push_back(make_record(anbd_pkg::STATUS_JUNK, unit_num, '0,
                                                 anbd_pkg::PREFIX_NONE, len,
                                                 anbd_pkg::ZERO_BYTE));
      end
      in_sync      = 1'b1;
      unit_active  = 1'b1;
      open_start   = pos - OFFSET_BITS'(zeros);
      open_prefix  = pre;
      hdr_captured = 1'b0;
      hdr_byte     = anbd_pkg::ZERO_BYTE;
      unit_bytes   = '0;
      zeros_seen   = '0;
    end else begin
      if (in_sync) begin
        if (!hdr_captured) begin
          hdr_byte     = b;
          hdr_captured = 1'b1;
        end
        if (unit_bytes != LEN_MAX) unit_bytes++;
      end else if (junk_bytes != LEN_MAX) begin
        junk_bytes++;
      end
      if (b == anbd_pkg::ZERO_BYTE) begin
        if (zeros_seen != anbd_pkg::ZRUN_MAX) zeros_seen++;
      end else begin
        zeros_seen = '0;
      end
    end
    stream_pos = pos + 1'b1;

    // end of stream flushes the open unit with its trailing zeros kept
    if (eos) begin
      if (!sc) begin
        if (in_sync && unit_active)
          expected_records.push_back(make_record(
              (unit_bytes == LEN_MAX) ? anbd_pkg::STATUS_SAT : anbd_pkg::STATUS_DONE,
              unit_num, open_start, open_prefix, unit_bytes, hdr_byte));
        else if (!in_sync && junk_bytes != '0)
          expected_records.push_back(make_record(anbd_pkg::STATUS_JUNK, unit_num, '0,
                                                 anbd_pkg::PREFIX_NONE, junk_bytes,
                                                 anbd_pkg::ZERO_BYTE));
      end
      clear_state();
    end
  endtask

  task automatic check_record();
    nal_record_t want;
    if (expected_records.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected record: status %0d index %0d offset %0d prefix %0d len %0d",
                 out_result_status, out_unit_index, out_start_offset, out_prefix_length,
                 out_payload_length);
    end else begin
      want = expected_records.pop_front();
      if (out_result_status !== want.status || out_unit_index !== want.index ||
          out_start_offset !== want.offset || out_prefix_length !== want.prefix ||
          out_payload_length !== want.length || out_forbidden_bit !== want.forbidden ||
          out_ref_idc !== want.nri || out_unit_type !== want.nal_type) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("record %0d mismatch, expected: st %0d idx %0d off %0d pre %0d len %0d",
                   records_checked, want.status, want.index, want.offset, want.prefix,
                   want.length);
          $display("  hdr f %0d nri %0d type %0d / actual: st %0d idx %0d off %0d pre %0d",
                   want.forbidden, want.nri, want.nal_type, out_result_status,
                   out_unit_index, out_start_offset, out_prefix_length);
          $display("  len %0d hdr f %0d nri %0d type %0d", out_payload_length,
                   out_forbidden_bit, out_ref_idc, out_unit_type);
        end
      end
    end
    records_checked++;
    if (out_result_status == anbd_pkg::STATUS_JUNK) junk_records++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_records.delete();
    end else begin
      if (out_valid && out_ready) check_record();
      if (in_valid && in_ready) begin
        bytes_seen++;
        predict_byte(in_data_byte, in_end_of_stream);
      end
    end
    pending_count <= expected_records.size();
  end

endmodule

// ----- test/annexb_nal_unit_delimiter_tb.sv -----
module annexb_nal_unit_delimiter_tb;

  localparam int unsigned LEN_BITS    = 24;
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned ITEM_TARGET = 580;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_START  = 150;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_START = 650;
  localparam int unsigned QUIET_END   = 950;

  logic                          clk;
  logic                          rst_n            = 1'b0;
  logic                          in_valid         = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_data_byte     = anbd_pkg::ZERO_BYTE;
  logic                          in_end_of_stream = 1'b0;
  logic                          out_valid;
  logic                          out_ready        = 1'b0;
  logic [1:0]                    out_result_status;
  logic [anbd_pkg::IDX_BITS-1:0] out_unit_index;
  logic [OFFSET_BITS-1:0]        out_start_offset;
  logic [2:0]                    out_prefix_length;
  logic [LEN_BITS-1:0]           out_payload_length;
  logic                          out_forbidden_bit;
  logic [1:0]                    out_ref_idc;
  logic [4:0]                    out_unit_type;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned records_checked;
  int unsigned junk_records;
  int unsigned bytes_seen;

  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned stream_count = 0;
  logic [7:0]  stream_q[$];

  annexb_nal_unit_delimiter #(
    .LEN_BITS    (LEN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_stream   (in_end_of_stream),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_status  (out_result_status),
    .out_unit_index     (out_unit_index),
    .out_start_offset   (out_start_offset),
    .out_prefix_length  (out_prefix_length),
    .out_payload_length (out_payload_length),
    .out_forbidden_bit  (out_forbidden_bit),
    .out_ref_idc        (out_ref_idc),
    .out_unit_type      (out_unit_type)
  );

  nal_record_checker #(
    .LEN_BITS    (LEN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_record_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_stream   (in_end_of_stream),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_status  (out_result_status),
    .out_unit_index     (out_unit_index),
    .out_start_offset   (out_start_offset),
    .out_prefix_length  (out_prefix_length),
    .out_payload_length (out_payload_length),
    .out_forbidden_bit  (out_forbidden_bit),
    .out_ref_idc        (out_ref_idc),
    .out_unit_type      (out_unit_type),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .records_checked    (records_checked),
    .junk_records       (junk_records),
    .bytes_seen         (bytes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records still expected", cycle_count,
               pending_count);
      $display("** annexb_nal_unit_delimiter: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off while bytes keep coming, one quiet window
  initial begin : receiver
    int unsigned rx_cycles;
    rx_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      rx_cycles++;
      if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
        out_ready <= 1'b0;
      else if (rx_cycles >= QUIET_START && rx_cycles < QUIET_END)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= 17);
      @(posedge clk);
    end
  end

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return anbd_pkg::ZERO_BYTE;
    if (r < 33) return anbd_pkg::START_CODE_BYTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    // no gaps for a stretch in the middle of the run
    while (!(sent_count >= 250 && sent_count < 400) && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic flush_stream(input bit with_eos);
    foreach (stream_q[i])
      send_byte(stream_q[i], with_eos && (i == stream_q.size() - 1));
    stream_q.delete();
    if (with_eos) stream_count++;
  endtask

  task automatic add_start_code(input int unsigned zeros);
    repeat (zeros) stream_q.push_back(anbd_pkg::ZERO_BYTE);
    stream_q.push_back(anbd_pkg::START_CODE_BYTE);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned units;
    int unsigned zr;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // junk before a 4-byte start code, full header, empty unit, extra zeros,
    // stream end with trailing zero kept
    stream_q = '{8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01,
                 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h1F,
                 8'h00};
    flush_stream(1'b1);
    // start code at stream start, then stream ending on a start code
    stream_q = '{8'h00, 8'h00, 8'h01, 8'h41, 8'h00, 8'h00, 8'h01};
    flush_stream(1'b1);
    // lone byte that is also the stream end
    stream_q = '{8'h01};
    flush_stream(1'b1);

    while (sent_count < ITEM_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        repeat ($urandom_range(20, 1)) stream_q.push_back(rand_byte());
        flush_stream($urandom_range(1));
      end else begin
        if ($urandom_range(99) < 25)
          repeat ($urandom_range(6, 1)) stream_q.push_back(rand_byte());
        units = $urandom_range(6, 1);
        repeat (units) begin
          zr = $urandom_range(99);
          add_start_code(zr < 45 ? 2 : (zr < 85 ? 3 : $urandom_range(6, 4)));
          if ($urandom_range(99) >= 8) begin
            stream_q.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(12)) stream_q.push_back(rand_byte());
          end
        end
        if ($urandom_range(99) < 10) add_start_code($urandom_range(3, 2));
        flush_stream($urandom_range(99) < 75);
      end
    end
    stream_q.push_back(8'h5A);
    flush_stream(1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d streams; %0d records checked, %0d of them leading junk",
             bytes_seen, stream_count, records_checked, junk_records);
    $display("covered both start code forms, extra zeros, empty units and stream ends");
    if (fail_count == 0 && pending_count == 0) begin
      $display("** annexb_nal_unit_delimiter: PASSED **");
    end else begin
      $display("%0d failures, %0d records never arrived", fail_count, pending_count);
      $display("** annexb_nal_unit_delimiter: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/anbd_pkg.sv
rtl/anbd_in_stage.sv
rtl/anbd_core.sv
rtl/annexb_nal_unit_delimiter.sv
rtl/anbd_checker.sv
test/nal_record_checker.sv
test/annexb_nal_unit_delimiter_tb.sv
